>>> src/mlfb_pkg.sv
`timescale 1ns / 1ps
package mlfb_pkg;

  localparam int FORWARD_PAD_BYTES = 16;
  localparam int QUEUE_DEPTH       = 4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 40;

  localparam logic [CFG_IDX_W-1:0] CFG_TERM_ADDR = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FWD_PORT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FWD_CTRL  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MSG_TO    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BYTE_TO   = 3'd4;

  // input command codes
  localparam logic [2:0] CMD_FWD_START = 3'd0;
  localparam logic [2:0] CMD_ANS_START = 3'd1;
  localparam logic [2:0] CMD_LOGIN     = 3'd2;
  localparam logic [2:0] CMD_HEARTBEAT = 3'd3;
  localparam logic [2:0] CMD_CONFIRM   = 3'd4;
  localparam logic [2:0] CMD_PAYLOAD   = 3'd5;

  typedef enum logic [2:0] {
    OP_FWD     = 3'd0,
    OP_ANS     = 3'd1,
    OP_LOGIN   = 3'd2,
    OP_HEART   = 3'd3,
    OP_CONFIRM = 3'd4,
    OP_DATA    = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_FWD  = 2'd1,
    KIND_ANS  = 2'd2
  } kind_t;

  typedef struct packed {
    op_t        op;
    kind_t      kind;    // trailer style of the frame this job belongs to
    logic       close;   // emit trailer after the body
    logic [3:0] seq;
    logic [7:0] len;
    logic [7:0] data;
  } job_t;

  typedef struct packed {
    logic [39:0] term_addr;
    logic [7:0]  fwd_port;
    logic [7:0]  fwd_ctrl;
    logic [7:0]  msg_to;
    logic [7:0]  byte_to;
  } cfg_t;

  localparam logic [7:0] BYTE_START = 8'h68;
  localparam logic [7:0] BYTE_END   = 8'h16;

endpackage

>>> src/mlfb_front.sv
`timescale 1ns / 1ps
module mlfb_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [2:0]          in_tuser,
  input  logic [15:0]         in_tdata,
  input  logic                q_full,
  output logic                q_push,
  output mlfb_pkg::job_t      q_job
);

  logic [3:0]          seq_r, seq_nxt;
  logic [7:0]          left_r, left_nxt;
  mlfb_pkg::kind_t     open_r, open_nxt;
  logic                accept;
  logic [7:0]          len;
  logic [7:0]          data;

  assign in_tready = ~q_full;
  assign accept    = in_tvalid & ~q_full;
  assign len       = in_tdata[7:0];
  assign data      = in_tdata[15:8];

  always_comb begin
    seq_nxt  = seq_r;
    left_nxt = left_r;
    open_nxt = open_r;
    q_push   = 1'b0;
    q_job.op    = mlfb_pkg::OP_DATA;
    q_job.kind  = mlfb_pkg::KIND_NONE;
    q_job.close = 1'b1;
    q_job.seq   = seq_r;
    q_job.len   = len;
    q_job.data  = data;
    if (accept) begin
      case (in_tuser)
        mlfb_pkg::CMD_FWD_START, mlfb_pkg::CMD_ANS_START: begin
          q_push = 1'b1;
          if (in_tuser == mlfb_pkg::CMD_FWD_START) begin
            q_job.op   = mlfb_pkg::OP_FWD;
            q_job.kind = mlfb_pkg::KIND_FWD;
          end else begin
            q_job.op   = mlfb_pkg::OP_ANS;
            q_job.kind = mlfb_pkg::KIND_ANS;
          end
          q_job.close = (len == 8'd0);
          seq_nxt  = seq_r + 4'd1;
          left_nxt = len;
          open_nxt = (len == 8'd0) ? mlfb_pkg::KIND_NONE : q_job.kind;
        end
        mlfb_pkg::CMD_LOGIN, mlfb_pkg::CMD_HEARTBEAT: begin
          q_push   = 1'b1;
          q_job.op = (in_tuser == mlfb_pkg::CMD_LOGIN) ? mlfb_pkg::OP_LOGIN
                                                       : mlfb_pkg::OP_HEART;
          seq_nxt  = seq_r + 4'd1;
          left_nxt = 8'd0;
          open_nxt = mlfb_pkg::KIND_NONE;
        end
        mlfb_pkg::CMD_CONFIRM: begin
          q_push   = 1'b1;
          q_job.op = mlfb_pkg::OP_CONFIRM;
          left_nxt = 8'd0;
          open_nxt = mlfb_pkg::KIND_NONE;
        end
        mlfb_pkg::CMD_PAYLOAD: begin
          // drop payload when no frame is open
          if (open_r != mlfb_pkg::KIND_NONE) begin
            q_push      = 1'b1;
            q_job.op    = mlfb_pkg::OP_DATA;
            q_job.kind  = open_r;
            q_job.close = (left_r == 8'd1);
            left_nxt    = left_r - 8'd1;
            if (left_r == 8'd1) begin
              open_nxt = mlfb_pkg::KIND_NONE;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r  <= 4'd0;
      left_r <= 8'd0;
      open_r <= mlfb_pkg::KIND_NONE;
    end else begin
      seq_r  <= seq_nxt;
      left_r <= left_nxt;
      open_r <= open_nxt;
    end
  end

endmodule

>>> src/mlfb_queue.sv
`timescale 1ns / 1ps
module mlfb_queue #(
  parameter int DEPTH = mlfb_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  mlfb_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output mlfb_pkg::job_t head_job,
  output logic           empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  mlfb_pkg::job_t   mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign head_job = mem_r[rd_ptr_r];
  assign do_push  = push & ~full;
  assign do_pop   = pop & ~empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

>>> src/mlfb_back.sv
`timescale 1ns / 1ps
module mlfb_back #(
  parameter int FORWARD_PAD_BYTES = mlfb_pkg::FORWARD_PAD_BYTES
) (
  input  logic           clk,
  input  logic           rst_n,
  input  mlfb_pkg::cfg_t cfg,
  input  mlfb_pkg::job_t head_job,
  input  logic           q_empty,
  output logic           q_pop,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [7:0]     out_tdata,
  output logic           out_tlast
);

  localparam int IDX_MAX = (FORWARD_PAD_BYTES > 24) ? FORWARD_PAD_BYTES : 24;
  localparam int IDX_W   = $clog2(IDX_MAX + 1);

  typedef enum logic [3:0] {
    S_BODY = 4'b0001,
    S_PAD  = 4'b0010,
    S_CHK  = 4'b0100,
    S_END  = 4'b1000
  } state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [7:0]       chk_r, chk_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_byte_r;
  logic             out_last_r;
  logic [7:0]       byte_v;
  logic             last_v;
  logic             fire;
  logic [IDX_W-1:0] body_last;
  logic [IDX_W-1:0] pad_cnt;
  logic [7:0]       len_byte;
  logic [7:0]       len_sum;

  function automatic logic [7:0] addr_byte(input logic [39:0] a, input logic [4:0] i);
    logic [7:0] b;
    case (i)
      5'd7:    b = a[7:0];
      5'd8:    b = a[15:8];
      5'd9:    b = a[23:16];
      5'd10:   b = a[31:24];
      default: b = a[39:32];
    endcase
    return b;
  endfunction

  assign fire = ~q_empty & (~out_valid_r | out_tready);

  // length byte: ((len + base) mod 256) << 2 | 2 for forward and answer, 0x32 otherwise
  always_comb begin
    case (head_job.op)
      mlfb_pkg::OP_FWD: len_sum = head_job.len + 8'd34;
      mlfb_pkg::OP_ANS: len_sum = head_job.len + 8'd17;
      default:          len_sum = 8'd0;
    endcase
    if (head_job.op == mlfb_pkg::OP_FWD || head_job.op == mlfb_pkg::OP_ANS) begin
      len_byte = {len_sum[5:0], 2'b10};
    end else begin
      len_byte = 8'h32;
    end
  end

  always_comb begin
    case (head_job.op)
      mlfb_pkg::OP_FWD:     body_last = IDX_W'(23);
      mlfb_pkg::OP_ANS:     body_last = IDX_W'(20);
      mlfb_pkg::OP_CONFIRM: body_last = IDX_W'(18);
      mlfb_pkg::OP_DATA:    body_last = IDX_W'(0);
      default:              body_last = IDX_W'(17);
    endcase
    case (head_job.kind)
      mlfb_pkg::KIND_FWD: pad_cnt = IDX_W'(FORWARD_PAD_BYTES);
      mlfb_pkg::KIND_ANS: pad_cnt = IDX_W'(2);
      default:            pad_cnt = '0;
    endcase
  end

  // byte of the frame body at the current index
  logic [7:0] body_byte;
  logic [4:0] bidx;
  assign bidx = idx_r[4:0];

  always_comb begin
    body_byte = 8'h00;
    if (head_job.op == mlfb_pkg::OP_DATA) begin
      body_byte = head_job.data;
    end else begin
      case (bidx)
        5'd0, 5'd5: body_byte = mlfb_pkg::BYTE_START;
        5'd1, 5'd3: body_byte = len_byte;
        5'd2, 5'd4: body_byte = 8'h00;
        5'd6: begin
          case (head_job.op)
            mlfb_pkg::OP_FWD:                    body_byte = 8'h4b;
            mlfb_pkg::OP_ANS:                    body_byte = 8'h98;
            mlfb_pkg::OP_LOGIN, mlfb_pkg::OP_HEART: body_byte = 8'hd9;
            default:                             body_byte = 8'h00;
          endcase
        end
        5'd7, 5'd8, 5'd9, 5'd10, 5'd11: body_byte = addr_byte(cfg.term_addr, bidx);
        default: begin
          case (head_job.op)
            mlfb_pkg::OP_FWD, mlfb_pkg::OP_ANS: begin
              case (bidx)
                5'd12:   body_byte = 8'h10;
                5'd13:   body_byte = {4'h6, head_job.seq};
                5'd16:   body_byte = 8'h01;
                5'd18:   body_byte = cfg.fwd_port;
                5'd19:   body_byte = (head_job.op == mlfb_pkg::OP_FWD) ? cfg.fwd_ctrl
                                                                       : head_job.len;
                5'd20:   body_byte = (head_job.op == mlfb_pkg::OP_FWD) ? cfg.msg_to
                                                                       : 8'h00;
                5'd21:   body_byte = cfg.byte_to;
                5'd22:   body_byte = head_job.len;
                default: body_byte = 8'h00;
              endcase
            end
            mlfb_pkg::OP_LOGIN, mlfb_pkg::OP_HEART: begin
              case (bidx)
                5'd12:   body_byte = 8'h02;
                5'd13:   body_byte = {4'h7, head_job.seq};
                5'd16:   body_byte = (head_job.op == mlfb_pkg::OP_LOGIN) ? 8'h01 : 8'h04;
                default: body_byte = 8'h00;
              endcase
            end
            default: begin
              case (bidx)
                5'd12:   body_byte = 8'h02;
                5'd14:   body_byte = 8'h65;
                5'd17:   body_byte = 8'h01;
                default: body_byte = 8'h00;
              endcase
            end
          endcase
        end
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    chk_nxt   = chk_r;
    q_pop     = 1'b0;
    last_v    = 1'b0;
    byte_v    = 8'h00;
    case (state_r)
      S_BODY: byte_v = body_byte;
      S_PAD: begin
        // answer trailer is 0x18 0x00, forward trailer is all zeros
        if (head_job.kind == mlfb_pkg::KIND_ANS && idx_r == '0) begin
          byte_v = 8'h18;
        end else begin
          byte_v = 8'h00;
        end
      end
      S_CHK: byte_v = chk_r;
      S_END: begin
        byte_v = mlfb_pkg::BYTE_END;
        last_v = 1'b1;
      end
      default: byte_v = 8'h00;
    endcase

    if (fire) begin
      if (state_r == S_BODY && idx_r == '0 && head_job.op != mlfb_pkg::OP_DATA) begin
        chk_nxt = byte_v;
      end else begin
        chk_nxt = chk_r ^ byte_v;
      end
      case (state_r)
        S_BODY: begin
          if (idx_r == body_last) begin
            idx_nxt = '0;
            if (!head_job.close) begin
              q_pop = 1'b1;
            end else if (pad_cnt == '0) begin
              state_nxt = S_CHK;
            end else begin
              state_nxt = S_PAD;
            end
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
        S_PAD: begin
          if (idx_r == pad_cnt - 1'b1) begin
            idx_nxt   = '0;
            state_nxt = S_CHK;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
        S_CHK: state_nxt = S_END;
        S_END: begin
          q_pop     = 1'b1;
          state_nxt = S_BODY;
        end
        default: state_nxt = S_BODY;
      endcase
    end

    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_BODY;
      idx_r       <= '0;
      chk_r       <= 8'h00;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      chk_r       <= chk_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_byte_r <= byte_v;
      out_last_r <= last_v;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;

endmodule

>>> src/meter_link_frame_builder_unit.sv
`timescale 1ns / 1ps
// Meter link frame builder.
// Input stream: in_tuser carries the command (forward start, answer start,
// login, heartbeat, confirm, payload byte); in_tdata carries payload length
// and data byte. Output stream: one frame byte per item on out_tdata, with
// out_tlast high on the closing 0x16 byte of each frame.
// A front stage accepts one item per cycle while the queue is not full,
// tracks the sequence counter and the open frame, and queues a job for each
// item it does not drop; a back sequencer expands each job into bytes, one
// per cycle while out_tready is high, into an output register. An accepted
// item is written into the queue, and the back registers its first byte into
// the output register with out_tvalid high. A start item yields 21 to
// FORWARD_PAD_BYTES + 26 bytes, so in_tready drops once QUEUE_DEPTH jobs
// wait. A payload byte yields one byte; the one that closes its frame adds
// the trailer (FORWARD_PAD_BYTES + 2 bytes for forward, 4 for answer).
// Reset (synchronous, rst_n low) clears the queue, sequence counter and open
// frame, and loads register defaults (port 4, control 0x6b, timeouts 1).
// When out_tready is low and out_tvalid high, the output register holds its
// byte and the back stops; the front keeps accepting until the queue is full.
module meter_link_frame_builder_unit #(
  parameter int FORWARD_PAD_BYTES = mlfb_pkg::FORWARD_PAD_BYTES,
  parameter int QUEUE_DEPTH       = mlfb_pkg::QUEUE_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [2:0]                       in_tuser,  // command
  input  logic [15:0]                      in_tdata,  // payload_length, data_byte
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [7:0]                       out_tdata, // frame_byte
  output logic                             out_tlast,
  input  logic                             cfg_we,
  input  logic [mlfb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mlfb_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  mlfb_pkg::cfg_t cfg_r;
  mlfb_pkg::job_t push_job;
  mlfb_pkg::job_t head_job;
  logic           q_push, q_pop, q_full, q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.term_addr <= 40'd0;
      cfg_r.fwd_port  <= 8'd4;
      cfg_r.fwd_ctrl  <= 8'h6b;
      cfg_r.msg_to    <= 8'd1;
      cfg_r.byte_to   <= 8'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        mlfb_pkg::CFG_TERM_ADDR: cfg_r.term_addr <= cfg_wdata;
        mlfb_pkg::CFG_FWD_PORT:  cfg_r.fwd_port  <= cfg_wdata[7:0];
        mlfb_pkg::CFG_FWD_CTRL:  cfg_r.fwd_ctrl  <= cfg_wdata[7:0];
        mlfb_pkg::CFG_MSG_TO:    cfg_r.msg_to    <= cfg_wdata[7:0];
        mlfb_pkg::CFG_BYTE_TO:   cfg_r.byte_to   <= cfg_wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  mlfb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (push_job)
  );

  mlfb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .head_job (head_job),
    .empty    (q_empty)
  );

  mlfb_back #(
    .FORWARD_PAD_BYTES (FORWARD_PAD_BYTES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head_job   (head_job),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import mlfb_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE      = 12;
  localparam int IDLE_PCT    = 38;

  // spare command codes the block must ignore
  localparam logic [2:0] CMD_SPARE_A = 3'd6;
  localparam logic [2:0] CMD_SPARE_B = 3'd7;

  typedef struct {
    logic [7:0] frame_byte;
    logic       last_byte;
  } frame_out_t;

  class link_frame_tracker;
    logic [39:0] term_addr;
    logic [7:0]  fwd_port;
    logic [7:0]  fwd_ctrl;
    logic [7:0]  msg_to;
    logic [7:0]  byte_to;

    logic [3:0]  seq_count;
    logic [7:0]  xor_check;
    logic [7:0]  payload_left;
    kind_t       open_kind;

    frame_out_t  pending_bytes[$];
    int          err_count;
    int          n_items;
    int          n_bytes;
    int          n_frames;

    function new();
      term_addr    = '0;
      fwd_port     = 8'h04;
      fwd_ctrl     = 8'h6b;
      msg_to       = 8'h01;
      byte_to      = 8'h01;
      seq_count    = '0;
      xor_check    = '0;
      payload_left = '0;
      open_kind    = KIND_NONE;
      err_count    = 0;
      n_items      = 0;
      n_bytes      = 0;
      n_frames     = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_TERM_ADDR: term_addr = val[39:0];
        CFG_FWD_PORT:  fwd_port  = val[7:0];
        CFG_FWD_CTRL:  fwd_ctrl  = val[7:0];
        CFG_MSG_TO:    msg_to    = val[7:0];
        CFG_BYTE_TO:   byte_to   = val[7:0];
        default: ;
      endcase
    endfunction

    function void put(logic [7:0] b, logic last);
      frame_out_t e;
      e.frame_byte = b;
      e.last_byte  = last;
      pending_bytes.push_back(e);
      xor_check = xor_check ^ b;
    endfunction

    function void put_head(logic [7:0] len_byte, logic [7:0] ctrl);
      xor_check = '0;
      put(BYTE_START, 1'b0);
      put(len_byte, 1'b0);
      put(8'h00, 1'b0);
      put(len_byte, 1'b0);
      put(8'h00, 1'b0);
      put(BYTE_START, 1'b0);
      put(ctrl, 1'b0);
      for (int i = 0; i < 5; i++) put(term_addr[8*i +: 8], 1'b0);
    endfunction

    function void put_close();
      put(xor_check, 1'b0);
      put(BYTE_END, 1'b1);
      open_kind    = KIND_NONE;
      payload_left = '0;
    endfunction

    function void put_trailer();
      if (open_kind == KIND_FWD) begin
        for (int i = 0; i < FORWARD_PAD_BYTES; i++) put(8'h00, 1'b0);
      end else begin
        put(8'h18, 1'b0);
        put(8'h00, 1'b0);
      end
      put_close();
    endfunction

    // expand one accepted input item into the frame bytes it causes
    function void note_command(logic [2:0] cmd, logic [7:0] len, logic [7:0] data);
      logic [7:0] lb;
      n_items++;
      case (cmd)
        CMD_FWD_START, CMD_ANS_START: begin
          if (cmd == CMD_FWD_START) begin
            lb = ((len + 8'd34) << 2) | 8'h02;
            put_head(lb, 8'h4b);
          end else begin
            lb = ((len + 8'd17) << 2) | 8'h02;
            put_head(lb, 8'h98);
          end
          put(8'h10, 1'b0);
          put(8'h60 + seq_count, 1'b0);
          put(8'h00, 1'b0);
          put(8'h00, 1'b0);
          put(8'h01, 1'b0);
          put(8'h00, 1'b0);
          put(fwd_port, 1'b0);
          if (cmd == CMD_FWD_START) begin
            put(fwd_ctrl, 1'b0);
            put(msg_to, 1'b0);
            put(byte_to, 1'b0);
          end
          put(len, 1'b0);
          put(8'h00, 1'b0);
          seq_count    = seq_count + 4'd1;
          open_kind    = (cmd == CMD_FWD_START) ? KIND_FWD : KIND_ANS;
          payload_left = len;
          if (payload_left == 8'd0) put_trailer();
        end
        CMD_LOGIN, CMD_HEARTBEAT: begin
          open_kind    = KIND_NONE;
          payload_left = '0;
          put_head(8'h32, 8'hd9);
          put(8'h02, 1'b0);
          put(8'h70 + seq_count, 1'b0);
          put(8'h00, 1'b0);
          put(8'h00, 1'b0);
          put((cmd == CMD_LOGIN) ? 8'h01 : 8'h04, 1'b0);
          put(8'h00, 1'b0);
          seq_count = seq_count + 4'd1;
          put_close();
        end
        CMD_CONFIRM: begin
          open_kind    = KIND_NONE;
          payload_left = '0;
          put_head(8'h32, 8'h00);
          put(8'h02, 1'b0);
          put(8'h00, 1'b0);
          put(8'h65, 1'b0);
          put(8'h00, 1'b0);
          put(8'h00, 1'b0);
          put(8'h01, 1'b0);
          put(8'h00, 1'b0);
          put_close();
        end
        CMD_PAYLOAD: begin
          // drop payload when no frame is open
          if (open_kind != KIND_NONE) begin
            put(data, 1'b0);
            payload_left = payload_left - 8'd1;
            if (payload_left == 8'd0) put_trailer();
          end
        end
        default: ;
      endcase
    endfunction

    function void check_byte(logic [7:0] b, logic last);
      frame_out_t e;
      n_bytes++;
      if (last) n_frames++;
      if (pending_bytes.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("%0t: unexpected byte %02h last %0b", $realtime, b, last);
      end else begin
        e = pending_bytes.pop_front();
        if (e.frame_byte !== b || e.last_byte !== last) begin
          err_count++;
          if (err_count <= 10)
            $display("%0t: byte exp %02h/%0b got %02h/%0b", $realtime,
                     e.frame_byte, e.last_byte, b, last);
        end
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [2:0]            in_tuser;   // command
  logic [15:0]           in_tdata;   // payload_length, data_byte
  logic                  out_tvalid;
  logic                  out_tready;
  logic [7:0]            out_tdata;  // frame_byte
  logic                  out_tlast;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  link_frame_tracker frames;
  bit  tx_idle_en;
  bit  rx_idle_en;
  bit  hold_req;
  int  hold_left;
  int  cycles;

  meter_link_frame_builder_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // receiver: random stalls, or a long counted hold-off on request
  initial begin
    out_tready = 1'b0;
    hold_left  = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= rx_idle_en ? ($urandom_range(0, 99) >= IDLE_PCT) : 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) frames.check_byte(out_tdata, out_tlast);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_item(logic [2:0] cmd, logic [7:0] len, logic [7:0] data);
    while (tx_idle_en && $urandom_range(0, 99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {data, len};
    do @(posedge clk); while (!in_tready);
    frames.note_command(cmd, len, data);
    @(negedge clk);
  endtask

  task automatic load_config(logic [39:0] addr, logic [7:0] port, logic [7:0] ctrl,
                             logic [7:0] mto, logic [7:0] bto);
    logic [CFG_IDX_W-1:0]  idx [5];
    logic [CFG_DATA_W-1:0] val [5];
    idx = '{CFG_TERM_ADDR, CFG_FWD_PORT, CFG_FWD_CTRL, CFG_MSG_TO, CFG_BYTE_TO};
    val = '{addr, 40'(port), 40'(ctrl), 40'(mto), 40'(bto)};
    for (int i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= val[i];
      frames.set_reg(idx[i], val[i]);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // hold the sender until every expected byte is out, then let stray items settle
  task automatic wait_frames_out();
    in_tvalid <= 1'b0;
    while (frames.pending_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic run_directed();
    send_item(CMD_FWD_START, 8'd0, 8'h00);   // zero length: trailer right after header
    send_item(CMD_ANS_START, 8'd0, 8'hff);
    send_item(CMD_LOGIN, 8'hff, 8'h00);
    send_item(CMD_HEARTBEAT, 8'h00, 8'hff);
    send_item(CMD_CONFIRM, 8'h00, 8'h00);
    send_item(CMD_PAYLOAD, 8'h00, 8'hff);    // no open frame: dropped
    send_item(CMD_SPARE_A, 8'hff, 8'hff);
    send_item(CMD_SPARE_B, 8'h55, 8'haa);
    send_item(CMD_FWD_START, 8'd3, 8'h00);
    send_item(CMD_PAYLOAD, 8'hff, 8'h00);
    send_item(CMD_PAYLOAD, 8'h00, 8'hff);
    send_item(CMD_PAYLOAD, 8'haa, 8'h5a);
    send_item(CMD_ANS_START, 8'd2, 8'h00);
    send_item(CMD_PAYLOAD, 8'h00, 8'ha5);
    send_item(CMD_PAYLOAD, 8'h00, 8'h3c);
    // longest length, abandoned by a new start and then by confirm
    send_item(CMD_FWD_START, 8'd255, 8'h00);
    send_item(CMD_PAYLOAD, 8'h00, 8'h01);
    send_item(CMD_PAYLOAD, 8'h00, 8'h02);
    send_item(CMD_ANS_START, 8'd255, 8'h00);
    send_item(CMD_PAYLOAD, 8'h00, 8'h80);
    send_item(CMD_CONFIRM, 8'h00, 8'h00);
    send_item(CMD_FWD_START, 8'd4, 8'h00);
    send_item(CMD_PAYLOAD, 8'h00, 8'h7e);
    send_item(CMD_HEARTBEAT, 8'h00, 8'h00);
    send_item(CMD_PAYLOAD, 8'h00, 8'h11);
  endtask

  task automatic run_random(int target);
    int         sent;
    int         r;
    int         nb;
    logic [2:0] cmd;
    logic [7:0] len;
    sent = 0;
    while (sent < target) begin
      r = $urandom_range(0, 99);
      if (r < 62) begin
        // mostly complete frames; some cut short and abandoned
        cmd = $urandom_range(0, 1) ? CMD_ANS_START : CMD_FWD_START;
        len = ($urandom_range(0, 49) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(0, 12));
        nb = len;
        if (nb > 40) nb = $urandom_range(0, 20);
        else if ($urandom_range(0, 9) == 0) nb = $urandom_range(0, nb);
        send_item(cmd, len, 8'($urandom));
        for (int k = 0; k < nb; k++) send_item(CMD_PAYLOAD, 8'($urandom), 8'($urandom));
        sent += 1 + nb;
      end else if (r < 82) begin
        cmd = 3'($urandom_range(CMD_LOGIN, CMD_CONFIRM));
        send_item(cmd, 8'($urandom), 8'($urandom));
        sent++;
      end else if (r < 92) begin
        send_item(CMD_PAYLOAD, 8'($urandom), 8'($urandom));
        sent++;
      end else begin
        send_item($urandom_range(0, 1) ? CMD_SPARE_A : CMD_SPARE_B,
                  8'($urandom), 8'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    frames     = new();
    cycles     = 0;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tuser   = '0;
    in_tdata   = '0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_wdata  = '0;
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    hold_req   = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    run_directed();
    wait_frames_out();

    load_config({40{1'b1}}, 8'hff, 8'hff, 8'hff, 8'hff);
    run_random(140);
    wait_frames_out();

    // no idling on either side; a long receiver hold-off backs up the input
    load_config('0, 8'h00, 8'h00, 8'h00, 8'h00);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    hold_req   = 1'b1;
    run_random(110);
    wait_frames_out();

    load_config({8'($urandom), 32'($urandom)}, 8'($urandom), 8'($urandom),
                8'($urandom), 8'($urandom));
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    run_random(140);
    wait_frames_out();

    $display("covered %0d input items over 4 register settings, %0d frame bytes checked",
             frames.n_items, frames.n_bytes);
    $display("%0d frames closed, %0d mismatches", frames.n_frames, frames.err_count);
    if (frames.err_count == 0 && frames.pending_bytes.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/mlfb_pkg.sv
src/mlfb_front.sv
src/mlfb_queue.sv
src/mlfb_back.sv
src/meter_link_frame_builder_unit.sv
bench/tb_top.sv
